>>> rtl/core/tfc_pkg.sv
// Shared types and constants for the texture footprint calculator.
package tfc_pkg;

	// Field widths fixed by the descriptor format
	localparam int SIDE_W   = 13;
	localparam int LEVEL_W  = 4;
	localparam int BPP_W    = 3;
	localparam int FMT_W    = 2;
	localparam int DIM_W    = 2;
	localparam int DEPTH_W  = 10;
	localparam int PITCH_W  = 16;
	localparam int LEN_W    = 48;

	// Internal widths: one level's area, running area sum, scaled sum, rounded sum
	localparam int TERM_W   = 2 * SIDE_W;
	localparam int AREA_W   = TERM_W + 1;
	localparam int SCALE_W  = 5;
	localparam int SUM_W    = 30;
	localparam int RND_W    = SUM_W + 1;

	// Remainder walk over the scaled sum, one byte per step, MSB first
	localparam int DIGIT_W   = 8;
	localparam int MOD_STEPS = 4;
	localparam int MOD_W     = DIGIT_W * MOD_STEPS;
	localparam int MOD_IDX_W = 2;

	// Format classes
	localparam logic [FMT_W-1:0] FMT_PLAIN  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_LINEAR = 2'd1;
	localparam logic [FMT_W-1:0] FMT_BC8    = 2'd2;
	localparam logic [FMT_W-1:0] FMT_BC16   = 2'd3;

	localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
	localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

	localparam logic [SCALE_W-1:0] BLK8_BYTES  = 5'd8;
	localparam logic [SCALE_W-1:0] BLK16_BYTES = 5'd16;
	localparam logic [DEPTH_W-1:0] CUBE_FACES  = 10'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LEVEL,
		ST_DRAIN,
		ST_SCALE,
		ST_MOD,
		ST_ROUND,
		ST_MULT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 load;
		logic                 level;
		logic                 accum;
		logic                 scale;
		logic                 mod_step;
		logic [MOD_IDX_W-1:0] mod_idx;
		logic                 round;
		logic                 mult;
	} cmd_t;

	typedef struct packed {
		logic               linear;
		logic               skip;
		logic               cube;
		logic               dim3;
		logic [LEVEL_W-1:0] levels;
	} status_t;

endpackage

>>> rtl/core/tfc_ctrl.sv
// Sequencer for the texture footprint calculator.
module tfc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tfc_pkg::status_t   status,
	output tfc_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);

	tfc_pkg::state_t                state_q, state_d;
	logic [tfc_pkg::LEVEL_W-1:0]    cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.mod_idx = cnt_q[tfc_pkg::MOD_IDX_W-1:0];
		case (state_q)
			tfc_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = tfc_pkg::ST_DISPATCH;
				end
			end
			tfc_pkg::ST_DISPATCH: begin
				cnt_d = '0;
				if (status.skip)
					state_d = tfc_pkg::ST_DONE;
				else if (status.linear)
					state_d = tfc_pkg::ST_SCALE;
				else if (status.levels == '0)
					state_d = tfc_pkg::ST_DRAIN;
				else
					state_d = tfc_pkg::ST_LEVEL;
			end
			tfc_pkg::ST_LEVEL: begin
				cmd.level = 1'b1;
				cmd.accum = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == status.levels - 1'b1)
					state_d = tfc_pkg::ST_DRAIN;
			end
			tfc_pkg::ST_DRAIN: begin
				cmd.accum = 1'b1;
				state_d   = tfc_pkg::ST_SCALE;
			end
			tfc_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				cnt_d     = '0;
				if (!status.linear && status.cube)
					state_d = tfc_pkg::ST_MOD;
				else if (!status.linear && status.dim3)
					state_d = tfc_pkg::ST_MULT;
				else
					state_d = tfc_pkg::ST_DONE;
			end
			tfc_pkg::ST_MOD: begin
				cmd.mod_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == tfc_pkg::LEVEL_W'(tfc_pkg::MOD_STEPS - 1))
					state_d = tfc_pkg::ST_ROUND;
			end
			tfc_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = tfc_pkg::ST_MULT;
			end
			tfc_pkg::ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = tfc_pkg::ST_DONE;
			end
			tfc_pkg::ST_DONE: begin
				state_d = tfc_pkg::ST_IDLE;
			end
			default: begin
				state_d = tfc_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != tfc_pkg::ST_IDLE);
	assign done = (state_q == tfc_pkg::ST_DONE);

endmodule

>>> rtl/core/tfc_datapath.sv
// Datapath: descriptor registers, level multiplier, accumulator, alignment and scaling.
module tfc_datapath #(
	parameter int FACE_ALIGN = 128,
	parameter int MAX_SIDE   = 4096,
	parameter int MAX_LEVELS = 15
) (
	input  logic                          clk,
	input  tfc_pkg::cmd_t                 cmd,
	input  logic [tfc_pkg::FMT_W-1:0]     format_class,
	input  logic [tfc_pkg::BPP_W-1:0]     texel_bytes,
	input  logic [tfc_pkg::DIM_W-1:0]     dimensionality,
	input  logic                          is_cubemap,
	input  logic [tfc_pkg::SIDE_W-1:0]    base_width,
	input  logic [tfc_pkg::SIDE_W-1:0]    base_height,
	input  logic [tfc_pkg::DEPTH_W-1:0]   slice_count,
	input  logic [tfc_pkg::PITCH_W-1:0]   line_stride,
	input  logic [tfc_pkg::LEVEL_W-1:0]   level_count,
	output tfc_pkg::status_t              status,
	output logic [tfc_pkg::LEN_W-1:0]     byte_length,
	output logic                          bad_descriptor
);

	localparam int REM_W = $clog2(FACE_ALIGN + 1);
	localparam int T_W   = REM_W + tfc_pkg::DIGIT_W;
	localparam int PAD_W = tfc_pkg::SIDE_W + 1;
	localparam logic [T_W-1:0]   ALIGN_T = T_W'(FACE_ALIGN);
	localparam logic [REM_W-1:0] ALIGN_R = REM_W'(FACE_ALIGN);

	// One byte of Horner remainder: r*256 + d reduced by binary subtraction
	function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r,
	                                              input logic [tfc_pkg::DIGIT_W-1:0] d);
		logic [T_W-1:0] t;
		t = {r, d};
		for (int k = tfc_pkg::DIGIT_W - 1; k >= 0; k--) begin
			if (t >= (ALIGN_T << k))
				t = t - (ALIGN_T << k);
		end
		return t[REM_W-1:0];
	endfunction

	logic [tfc_pkg::FMT_W-1:0]    fmt_q;
	logic [tfc_pkg::BPP_W-1:0]    bpp_q;
	logic [tfc_pkg::DEPTH_W-1:0]  depth_q;
	logic [tfc_pkg::PITCH_W-1:0]  pitch_q;
	logic [tfc_pkg::SIDE_W-1:0]   w_q, h_q;
	logic [tfc_pkg::LEVEL_W-1:0]  lev_q;
	logic                         lin_q, skip_q, bad_q, cube_q, dim3_q;
	logic [tfc_pkg::TERM_W-1:0]   prod_q;
	logic [tfc_pkg::AREA_W-1:0]   acc_q;
	logic [REM_W-1:0]             rem_q;
	logic [tfc_pkg::LEN_W-1:0]    res_q;

	logic [tfc_pkg::SIDE_W-1:0]   w_clamp, h_clamp, wf, hf, op_w, op_h;
	logic [tfc_pkg::LEVEL_W-1:0]  lev_clamp;
	logic [PAD_W-1:0]             wp, hp;
	logic                         in_lin, in_bad, in_null;
	logic [tfc_pkg::SCALE_W-1:0]  scale;
	logic [tfc_pkg::AREA_W-1:0]   sc_a;
	logic [tfc_pkg::PITCH_W-1:0]  sc_b;
	logic [tfc_pkg::MOD_W-1:0]    mod_word;
	logic [tfc_pkg::DIGIT_W-1:0]  digit;
	logic [REM_W-1:0]             adj;
	logic [tfc_pkg::DEPTH_W-1:0]  factor;

	// Descriptor sanitising at load
	assign w_clamp   = (32'(base_width)  > MAX_SIDE) ? tfc_pkg::SIDE_W'(MAX_SIDE) : base_width;
	assign h_clamp   = (32'(base_height) > MAX_SIDE) ? tfc_pkg::SIDE_W'(MAX_SIDE) : base_height;
	assign lev_clamp = (32'(level_count) > MAX_LEVELS) ? tfc_pkg::LEVEL_W'(MAX_LEVELS)
	                                                   : level_count;
	assign in_lin    = (format_class == tfc_pkg::FMT_LINEAR);
	assign in_bad    = in_lin ? (is_cubemap || dimensionality != tfc_pkg::DIM_2D)
	                          : (is_cubemap && dimensionality == tfc_pkg::DIM_3D);
	assign in_null   = !in_lin && (dimensionality < tfc_pkg::DIM_2D);

	// Per-level operands: floor at 1, pad to 4x4 tiles for compressed formats
	assign wf   = (w_q == '0) ? tfc_pkg::SIDE_W'(1) : w_q;
	assign hf   = (h_q == '0) ? tfc_pkg::SIDE_W'(1) : h_q;
	assign wp   = (PAD_W'(wf) + PAD_W'(3)) >> 2;
	assign hp   = (PAD_W'(hf) + PAD_W'(3)) >> 2;
	assign op_w = (fmt_q == tfc_pkg::FMT_PLAIN) ? wf : tfc_pkg::SIDE_W'(wp);
	assign op_h = (fmt_q == tfc_pkg::FMT_PLAIN) ? hf : tfc_pkg::SIDE_W'(hp);

	always_comb begin
		case (fmt_q)
			tfc_pkg::FMT_PLAIN: scale = tfc_pkg::SCALE_W'(bpp_q);
			tfc_pkg::FMT_BC8:   scale = tfc_pkg::BLK8_BYTES;
			tfc_pkg::FMT_BC16:  scale = tfc_pkg::BLK16_BYTES;
			default:            scale = '0;
		endcase
	end

	// Shared scaling multiplier: area sum times bytes, or height times pitch
	assign sc_a = lin_q ? tfc_pkg::AREA_W'(h_q) : acc_q;
	assign sc_b = lin_q ? pitch_q : tfc_pkg::PITCH_W'(scale);

	assign mod_word = tfc_pkg::MOD_W'(res_q[tfc_pkg::SUM_W-1:0]);
	assign digit    = mod_word[tfc_pkg::DIGIT_W *
	                           (tfc_pkg::MOD_STEPS - 1 - int'(cmd.mod_idx)) +: tfc_pkg::DIGIT_W];
	assign adj      = (rem_q == '0) ? '0 : (ALIGN_R - rem_q);
	assign factor   = cube_q ? tfc_pkg::CUBE_FACES : depth_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fmt_q   <= format_class;
			bpp_q   <= texel_bytes;
			depth_q <= slice_count;
			pitch_q <= line_stride;
			w_q     <= w_clamp;
			h_q     <= h_clamp;
			lev_q   <= lev_clamp;
			lin_q   <= in_lin;
			bad_q   <= in_bad;
			skip_q  <= in_bad || in_null;
			cube_q  <= is_cubemap;
			dim3_q  <= (dimensionality == tfc_pkg::DIM_3D);
			prod_q  <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			res_q   <= '0;
		end else begin
			if (cmd.level) begin
				prod_q <= op_w * op_h;
				w_q    <= w_q >> 1;
				h_q    <= h_q >> 1;
			end
			if (cmd.accum)
				acc_q <= acc_q + tfc_pkg::AREA_W'(prod_q);
			if (cmd.scale)
				res_q <= tfc_pkg::LEN_W'(sc_a * sc_b);
			if (cmd.mod_step)
				rem_q <= rem_step(rem_q, digit);
			if (cmd.round)
				res_q <= res_q + tfc_pkg::LEN_W'(adj);
			if (cmd.mult)
				res_q <= tfc_pkg::LEN_W'(res_q[tfc_pkg::RND_W-1:0] * factor);
		end
	end

	assign status.linear = lin_q;
	assign status.skip   = skip_q;
	assign status.cube   = cube_q;
	assign status.dim3   = dim3_q;
	assign status.levels = lev_q;

	assign byte_length    = res_q;
	assign bad_descriptor = bad_q;

endmodule

>>> rtl/core/texture_footprint_calculator_core.sv
// Top level of the texture footprint calculator: sequencer plus datapath.
// From the accepting edge, n mip levels: dispatch, then done if rejected or 1D; linear
//   scales; swizzled 2D walks n levels, drains, scales; 3D adds the multiply; cubemap adds
//   remainder walk, round, multiply; worst case a 15-level cubemap. One descriptor at a
//   time: busy holds through the done beat; the one-level-per-cycle walk dominates.
// Results cannot be stalled. Async active-low reset idles the sequencer; data regs unreset.
module texture_footprint_calculator_core #(
	parameter int FACE_ALIGN = 128,
	parameter int MAX_SIDE   = 4096,
	parameter int MAX_LEVELS = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic [tfc_pkg::FMT_W-1:0]     format_class,
	input  logic [tfc_pkg::BPP_W-1:0]     texel_bytes,
	input  logic [tfc_pkg::DIM_W-1:0]     dimensionality,
	input  logic                          is_cubemap,
	input  logic [tfc_pkg::SIDE_W-1:0]    base_width,
	input  logic [tfc_pkg::SIDE_W-1:0]    base_height,
	input  logic [tfc_pkg::DEPTH_W-1:0]   slice_count,
	input  logic [tfc_pkg::PITCH_W-1:0]   line_stride,
	input  logic [tfc_pkg::LEVEL_W-1:0]   level_count,
	output logic [tfc_pkg::LEN_W-1:0]     byte_length,
	output logic                          bad_descriptor
);

	// Command and status buses between sequencer and datapath
	tfc_pkg::cmd_t    cmd;
	tfc_pkg::status_t status;

	// Sequencer: dispatch, per-level walk, scale, align, final multiply, done beat
	tfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: the descriptor is captured on the accepting edge and held for the item
	tfc_datapath #(
		.FACE_ALIGN (FACE_ALIGN),
		.MAX_SIDE   (MAX_SIDE),
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.format_class    (format_class),
		.texel_bytes     (texel_bytes),
		.dimensionality  (dimensionality),
		.is_cubemap      (is_cubemap),
		.base_width      (base_width),
		.base_height     (base_height),
		.slice_count     (slice_count),
		.line_stride     (line_stride),
		.level_count     (level_count),
		.status          (status),
		.byte_length     (byte_length),
		.bad_descriptor  (bad_descriptor)
	);

	// A done beat is a single cycle, and the block is then free again
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done beat longer than one cycle");

	// A rejected descriptor always reports zero length
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_descriptor) |-> (byte_length == '0))
		else $error("bad descriptor with non-zero length");

	// An accepted beat makes the block busy on the next cycle, with no result yet
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted beat did not start work");

	// The datapath is only loaded from idle on an accepted beat
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (start && !busy))
		else $error("descriptor loaded outside an accepted beat");

endmodule
